// File: hw/rtl/dspba_pkg.sv
// ----------------------------------------------------------------------------
// dspba_pkg
// Shared types and constants for the dual-sensor pitch bend averager.
// ----------------------------------------------------------------------------
package dspba_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 10;
  localparam int LO_W        = 11;
  localparam int HI_W        = 10;
  localparam int Q_W         = 15;
  localparam int BEND_W      = 16;
  localparam int CFG_W       = 15;
  localparam int CFG_ADDR_W  = 3;
  localparam int OP_W        = 2;

  // Q14 unity
  localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

  // Reset values
  localparam logic [LO_W-1:0]  LO_RESET = 11'd160;
  localparam logic [HI_W-1:0]  HI_RESET = 10'd240;
  localparam logic [CFG_W-1:0] DZ_RESET = 15'd2458;
  localparam logic [CFG_W-1:0] FS_RESET = 15'd14746;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL_LO = 2'd1;
  localparam logic [OP_W-1:0] OP_CAL_HI = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Register indexes
  localparam logic REG_DEAD_ZONE  = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  // Shared divider geometry
  localparam int DIV_NUM_W = 30;
  localparam int DIV_DEN_W = 15;
  localparam int DIV_STEP  = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified item, front to back
  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SAMPLE_BITS-1:0] up;
    logic [SAMPLE_BITS-1:0] dn;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] pk;
  } cmd_t;

  // Result word, bend in the low bits
  typedef struct packed {
    logic                   pad;
    logic [SAMPLE_BITS-1:0] level_average;
    logic [HI_W-1:0]        high_bound;
    logic [LO_W-1:0]        low_bound;
    logic [BEND_W-1:0]      bend;
  } res_t;

  // Configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] dead_zone;
    logic [CFG_W-1:0] full_scale;
  } cfg_t;

endpackage

// File: hw/rtl/dspba_front.sv
// ----------------------------------------------------------------------------
// dspba_front
// Input stage: takes transfers, decodes the operation and precomputes the
// pair midpoint and maximum.
// ----------------------------------------------------------------------------
module dspba_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // up_sample, down_sample, zero pad
  input  logic [1:0]           in_tuser,   // operation
  output logic                 f_valid,
  input  logic                 f_ready,
  output dspba_pkg::cmd_t      f_data
);

  logic                            vld_r, vld_nxt;
  dspba_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [dspba_pkg::SAMPLE_BITS-1:0] up, dn;
  logic [dspba_pkg::SAMPLE_BITS:0]   pair_sum;
  logic                            accept;

  assign in_tready = !vld_r || f_ready;
  assign accept    = in_tvalid && in_tready;

  assign up = in_tdata[dspba_pkg::SAMPLE_BITS-1:0];
  assign dn = in_tdata[2*dspba_pkg::SAMPLE_BITS-1:dspba_pkg::SAMPLE_BITS];
  // rounded midpoint, ties up
  assign pair_sum = {1'b0, up} + {1'b0, dn} + (dspba_pkg::SAMPLE_BITS+1)'(1);

  // Next item register
  always_comb begin
    cmd_nxt = cmd_r;
    vld_nxt = vld_r;
    if (accept) begin
      cmd_nxt.op  = in_tuser;
      cmd_nxt.up  = up;
      cmd_nxt.dn  = dn;
      cmd_nxt.mid = pair_sum[dspba_pkg::SAMPLE_BITS:1];
      cmd_nxt.pk  = (up > dn) ? up : dn;
      vld_nxt     = 1'b1;
    end else if (f_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign f_valid = vld_r;
  assign f_data  = cmd_r;

endmodule

// File: hw/rtl/dspba_queue.sv
// ----------------------------------------------------------------------------
// dspba_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module dspba_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dspba_pkg::cmd_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output dspba_pkg::cmd_t out_data
);

  localparam int DEPTH = dspba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dspba_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_ready  = (cnt_r != CNT_W'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

endmodule

// File: hw/rtl/dspba_div.sv
// ----------------------------------------------------------------------------
// dspba_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dspba_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dspba_pkg::DIV_NUM_W-1:0] num,
  input  logic [dspba_pkg::DIV_DEN_W-1:0] den,
  output logic                            done,
  output logic [dspba_pkg::DIV_NUM_W-1:0] quot
);

  localparam int NUM_W = dspba_pkg::DIV_NUM_W;
  localparam int DEN_W = dspba_pkg::DIV_DEN_W;
  localparam int STEP  = dspba_pkg::DIV_STEP;
  localparam int ITER  = NUM_W / STEP;
  localparam int CNT_W = $clog2(ITER);

  logic [NUM_W-1:0] acc_r, acc_nxt;   // dividend bits out, quotient bits in
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    logic [DEN_W:0]   r;
    logic [NUM_W-1:0] a;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r        = rem_r;
    a        = acc_r;
    if (start) begin
      acc_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(ITER - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift-subtract steps
      for (int i = 0; i < STEP; i++) begin
        r = {r[DEN_W-1:0], a[NUM_W-1]};
        a = {a[NUM_W-2:0], 1'b0};
        if (r >= {1'b0, den_r}) begin
          r    = r - {1'b0, den_r};
          a[0] = 1'b1;
        end
      end
      acc_nxt = a;
      rem_nxt = r;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

// File: hw/rtl/dspba_back.sv
// ----------------------------------------------------------------------------
// dspba_back
// Execution part: sample scaling, window update, means, calibration and
// bend mapping, sequenced over one shared divider.
// ----------------------------------------------------------------------------
module dspba_back #(
  parameter int WINDOW = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  dspba_pkg::cmd_t q_data,
  input  dspba_pkg::cfg_t cfg,
  output logic            out_tvalid,
  input  logic            out_tready,
  output dspba_pkg::res_t out_res
);

  localparam int SB     = dspba_pkg::SAMPLE_BITS;
  localparam int QW     = dspba_pkg::Q_W;
  localparam int NUM_W  = dspba_pkg::DIV_NUM_W;
  localparam int DEN_W  = dspba_pkg::DIV_DEN_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int DSUM_W = 16 + $clog2(WINDOW);
  localparam int MSUM_W = SB + $clog2(WINDOW);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SC_UP = 4'd1;
  localparam logic [3:0] ST_SC_DN = 4'd2;
  localparam logic [3:0] ST_UPD   = 4'd3;
  localparam logic [3:0] ST_LVL   = 4'd4;
  localparam logic [3:0] ST_PK    = 4'd5;
  localparam logic [3:0] ST_CAL   = 4'd6;
  localparam logic [3:0] ST_MEAN  = 4'd7;
  localparam logic [3:0] ST_BEND  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]                     state_r, state_nxt;
  logic                           pend_r, pend_nxt;
  dspba_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [QW-1:0]                  su_r, su_nxt;
  logic [QW-1:0]                  sd_r, sd_nxt;
  logic [DSUM_W-1:0]              dsum_r, dsum_nxt;
  logic [MSUM_W-1:0]              msum_r, msum_nxt;
  logic [MSUM_W-1:0]              psum_r, psum_nxt;
  logic [SLOT_W-1:0]              slot_r, slot_nxt;
  logic                           wrapped_r, wrapped_nxt;
  logic [dspba_pkg::LO_W-1:0]     lo_r, lo_nxt;
  logic [dspba_pkg::HI_W-1:0]     hi_r, hi_nxt;
  logic [SB-1:0]                  lvl_r, lvl_nxt;
  logic [SB-1:0]                  pmean_r, pmean_nxt;
  logic [QW-1:0]                  m_r, m_nxt;
  logic [dspba_pkg::BEND_W-1:0]   bend_r, bend_nxt;
  logic                           ovld_r, ovld_nxt;
  dspba_pkg::res_t                ores_r, ores_nxt;

  // Window memories
  logic [15:0]   dwin_mem [WINDOW];
  logic [SB-1:0] mwin_mem [WINDOW];
  logic [SB-1:0] pwin_mem [WINDOW];
  logic [15:0]   dwin_rd_r;
  logic [SB-1:0] mwin_rd_r, pwin_rd_r;
  logic          win_we;
  logic [15:0]   delta;

  // Divider hookup
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  dspba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sample scaling terms
  logic [SB-1:0]      x_sel;
  logic [SB:0]        x_ext, x_clip, diff11, span11;
  logic               scale_degen;
  logic [QW-1:0]      scale_flat;
  logic [NUM_W-1:0]   scale_num;
  logic [DEN_W-1:0]   scale_den;

  assign x_sel       = (state_r == ST_SC_UP) ? cmd_r.up : cmd_r.dn;
  assign x_ext       = {1'b0, x_sel};
  assign scale_degen = ({1'b0, hi_r} <= lo_r);
  assign scale_flat  = (x_ext > lo_r) ? dspba_pkg::Q_ONE : '0;
  assign x_clip      = (x_ext < lo_r) ? lo_r :
                       (x_ext > {1'b0, hi_r}) ? {1'b0, hi_r} : x_ext;
  assign diff11      = x_clip - lo_r;
  assign span11      = {1'b0, hi_r} - lo_r;
  assign scale_num   = NUM_W'({diff11[SB-1:0], 14'd0}) + NUM_W'(span11[SB-1:1]);
  assign scale_den   = DEN_W'(span11[SB-1:0]);

  // Mean terms, round half up over the window
  logic               dneg;
  logic [DSUM_W-1:0]  dmag;
  logic [NUM_W-1:0]   dmean_num, lmean_num, pmean_num;
  logic [DEN_W-1:0]   mean_den;

  assign dneg      = dsum_r[DSUM_W-1];
  assign dmag      = dneg ? (DSUM_W'(0) - dsum_r) : dsum_r;
  assign dmean_num = NUM_W'({dmag, 1'b0}) + NUM_W'(WINDOW);
  assign lmean_num = NUM_W'({msum_r, 1'b0}) + NUM_W'(WINDOW);
  assign pmean_num = NUM_W'({psum_r, 1'b0}) + NUM_W'(WINDOW);
  assign mean_den  = DEN_W'(2 * WINDOW);

  // Calibration terms
  logic [13:0]        cal_prod;
  logic [NUM_W-1:0]   cal_num;

  assign cal_prod = (cmd_r.op == dspba_pkg::OP_CAL_LO) ?
                    ({4'd0, lvl_r} * 14'd11 + 14'd5) :
                    ({4'd0, pmean_r} * 14'd9 + 14'd5);
  assign cal_num  = NUM_W'(cal_prod);

  // Bend mapping terms
  logic [QW-1:0]      bdiff, bspan, bmag;
  logic [NUM_W-1:0]   bend_num;
  logic [15:0]        bmag16;

  assign bdiff    = m_r - cfg.dead_zone;
  assign bspan    = cfg.full_scale - cfg.dead_zone;
  assign bend_num = NUM_W'({bdiff, 14'd0}) + NUM_W'(bspan[QW-1:1]);
  assign bmag     = (div_quot > NUM_W'(dspba_pkg::Q_ONE)) ? dspba_pkg::Q_ONE :
                    div_quot[QW-1:0];
  assign bmag16   = {1'b0, bmag};

  assign delta = {1'b0, su_r} - {1'b0, sd_r};

  // Sequencer
  always_comb begin
    logic [15:0]   old_d;
    logic [SB-1:0] old_m, old_p;
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    cmd_nxt     = cmd_r;
    su_nxt      = su_r;
    sd_nxt      = sd_r;
    dsum_nxt    = dsum_r;
    msum_nxt    = msum_r;
    psum_nxt    = psum_r;
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    lvl_nxt     = lvl_r;
    pmean_nxt   = pmean_r;
    m_nxt       = m_r;
    bend_nxt    = bend_r;
    ovld_nxt    = ovld_r;
    ores_nxt    = ores_r;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    win_we      = 1'b0;
    old_d       = wrapped_r ? dwin_rd_r : '0;
    old_m       = wrapped_r ? mwin_rd_r : '0;
    old_p       = wrapped_r ? pwin_rd_r : '0;

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_data;
          pend_nxt = 1'b0;
          case (q_data.op)
            dspba_pkg::OP_SAMPLE: state_nxt = ST_SC_UP;
            dspba_pkg::OP_CAL_HI: state_nxt = ST_PK;
            default:              state_nxt = ST_LVL;
          endcase
        end
      end
      ST_SC_UP, ST_SC_DN: begin
        if (!pend_r) begin
          if (scale_degen) begin
            if (state_r == ST_SC_UP) begin
              su_nxt    = scale_flat;
              state_nxt = ST_SC_DN;
            end else begin
              sd_nxt    = scale_flat;
              state_nxt = ST_UPD;
            end
          end else begin
            div_start = 1'b1;
            div_num   = scale_num;
            div_den   = scale_den;
            pend_nxt  = 1'b1;
          end
        end else if (div_done) begin
          pend_nxt = 1'b0;
          if (state_r == ST_SC_UP) begin
            su_nxt    = div_quot[QW-1:0];
            state_nxt = ST_SC_DN;
          end else begin
            sd_nxt    = div_quot[QW-1:0];
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        // replace the oldest entry and slide the running sums
        win_we   = 1'b1;
        dsum_nxt = dsum_r + {{(DSUM_W-16){delta[15]}}, delta}
                          - {{(DSUM_W-16){old_d[15]}}, old_d};
        msum_nxt = msum_r + MSUM_W'(cmd_r.mid) - MSUM_W'(old_m);
        psum_nxt = psum_r + MSUM_W'(cmd_r.pk) - MSUM_W'(old_p);
        if (slot_r == SLOT_W'(WINDOW - 1)) begin
          slot_nxt    = '0;
          wrapped_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        state_nxt = ST_LVL;
      end
      ST_LVL: begin
        if (!pend_r) begin
          div_start = 1'b1;
          div_num   = lmean_num;
          div_den   = mean_den;
          pend_nxt  = 1'b1;
        end else if (div_done) begin
          pend_nxt  = 1'b0;
          lvl_nxt   = div_quot[SB-1:0];
          state_nxt = ((cmd_r.op == dspba_pkg::OP_CAL_LO) ||
                       (cmd_r.op == dspba_pkg::OP_CAL_HI)) ? ST_CAL : ST_MEAN;
        end
      end
      ST_PK: begin
        if (!pend_r) begin
          div_start = 1'b1;
          div_num   = pmean_num;
          div_den   = mean_den;
          pend_nxt  = 1'b1;
        end else if (div_done) begin
          pend_nxt  = 1'b0;
          pmean_nxt = div_quot[SB-1:0];
          state_nxt = ST_LVL;
        end
      end
      ST_CAL: begin
        if (!pend_r) begin
          div_start = 1'b1;
          div_num   = cal_num;
          div_den   = DEN_W'(10);
          pend_nxt  = 1'b1;
        end else if (div_done) begin
          pend_nxt = 1'b0;
          if (cmd_r.op == dspba_pkg::OP_CAL_LO) begin
            lo_nxt = div_quot[dspba_pkg::LO_W-1:0];
          end else begin
            hi_nxt = div_quot[dspba_pkg::HI_W-1:0];
          end
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (!pend_r) begin
          div_start = 1'b1;
          div_num   = dmean_num;
          div_den   = mean_den;
          pend_nxt  = 1'b1;
        end else if (div_done) begin
          pend_nxt  = 1'b0;
          m_nxt     = div_quot[QW-1:0];
          state_nxt = ST_BEND;
        end
      end
      ST_BEND: begin
        if (!pend_r) begin
          if (m_r <= cfg.dead_zone) begin
            bend_nxt  = '0;
            state_nxt = ST_OUT;
          end else if (cfg.full_scale <= cfg.dead_zone) begin
            bend_nxt  = dneg ? (16'd0 - {1'b0, dspba_pkg::Q_ONE})
                             : {1'b0, dspba_pkg::Q_ONE};
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_num   = bend_num;
            div_den   = bspan;
            pend_nxt  = 1'b1;
          end
        end else if (div_done) begin
          pend_nxt  = 1'b0;
          bend_nxt  = dneg ? (16'd0 - bmag16) : bmag16;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt               = 1'b1;
          ores_nxt.pad           = 1'b0;
          ores_nxt.level_average = lvl_r;
          ores_nxt.high_bound    = hi_r;
          ores_nxt.low_bound     = lo_r;
          ores_nxt.bend          = bend_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_r    <= 1'b0;
      dsum_r    <= '0;
      msum_r    <= '0;
      psum_r    <= '0;
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      lo_r      <= dspba_pkg::LO_RESET;
      hi_r      <= dspba_pkg::HI_RESET;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      dsum_r    <= dsum_nxt;
      msum_r    <= msum_nxt;
      psum_r    <= psum_nxt;
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      ovld_r    <= ovld_nxt;
    end
    cmd_r   <= cmd_nxt;
    su_r    <= su_nxt;
    sd_r    <= sd_nxt;
    lvl_r   <= lvl_nxt;
    pmean_r <= pmean_nxt;
    m_r     <= m_nxt;
    bend_r  <= bend_nxt;
    ores_r  <= ores_nxt;
  end

  // Window memories: the current slot is written once per sample item and read through a register
  always_ff @(posedge clk) begin
    if (win_we) begin
      dwin_mem[slot_r] <= delta;
      mwin_mem[slot_r] <= cmd_r.mid;
      pwin_mem[slot_r] <= cmd_r.pk;
    end
    dwin_rd_r <= dwin_mem[slot_r];
    mwin_rd_r <= mwin_mem[slot_r];
    pwin_rd_r <= pwin_mem[slot_r];
  end

  assign out_tvalid = ovld_r;
  assign out_res    = ores_r;

endmodule

// File: hw/rtl/dual_sensor_pitch_bend_averager.sv
// ----------------------------------------------------------------------------
// dual_sensor_pitch_bend_averager
// Averages bend-up minus bend-down light readings over a sliding window and
// maps the mean to a Q14 pitch bend; also calibrates the raw bounds.
// ----------------------------------------------------------------------------
// Divisions: every division runs on the one shared divider; a sample pair
//   runs up to five of them, a low-bound calibration up to four, a
//   high-bound one up to five and an unused operation up to three.
// Items: the back part works on one item at a time; the queue holds later ones.
// Reset: synchronous, active low; windows read as zero until first written,
//   bounds return to 160 and 240, registers to their defaults.
// ----------------------------------------------------------------------------
module dual_sensor_pitch_bend_averager #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [9:0] up_sample, [19:10] down_sample
  input  logic [1:0]  in_tuser,    // [1:0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] bend, [26:16] low_bound,
                                   // [36:27] high_bound, [46:37] level_average
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [dspba_pkg::CFG_W-1:0]    dead_zone_r, dead_zone_nxt;
  logic [dspba_pkg::CFG_W-1:0]    full_scale_r, full_scale_nxt;
  logic                           cfg_wr;
  logic                           reg_idx;
  dspba_pkg::cfg_t                cfg;

  logic            f_valid, f_ready;
  dspba_pkg::cmd_t f_data;
  logic            q_valid, q_pop;
  dspba_pkg::cmd_t q_data;
  dspba_pkg::res_t out_res;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    dead_zone_nxt  = dead_zone_r;
    full_scale_nxt = full_scale_r;
    if (cfg_wr) begin
      if (reg_idx == dspba_pkg::REG_DEAD_ZONE) begin
        dead_zone_nxt = cfg_pwdata[dspba_pkg::CFG_W-1:0];
      end else begin
        full_scale_nxt = cfg_pwdata[dspba_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r  <= dspba_pkg::DZ_RESET;
      full_scale_r <= dspba_pkg::FS_RESET;
    end else begin
      dead_zone_r  <= dead_zone_nxt;
      full_scale_r <= full_scale_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == dspba_pkg::REG_FULL_SCALE) ?
                      32'(full_scale_r) : 32'(dead_zone_r);

  assign cfg.dead_zone  = dead_zone_r;
  assign cfg.full_scale = full_scale_r;

  // Front: accept and classify
  dspba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_data    (f_data)
  );

  // Queue between front and back
  dspba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_data)
  );

  // Back: execute
  dspba_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res;

  // Checks
  a_front_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !f_ready) |-> !in_tready)
    else $error("input taken while front stage is blocked");

  a_bend_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384 &&
                    $signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("bend outside full scale");

  a_low_bound_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[26:16] <= 11'd1126))
    else $error("low bound outside calibration range");

  a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !out_tvalid) || (q_valid && out_tvalid))
    else $error("queue popped while empty");

endmodule
